@@ src/key_matrix_debounce_ghost_macros.svh @@
// ----------------------------------------------------------------------------
// Key matrix debounce and ghost check: assertion macros
// Shared concurrent assertion forms used by the key matrix scanner.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_GHOST_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_GHOST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMDG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KMDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/kmdg_pkg.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce and ghost check: package
// Shared constants, types and helper functions for the scanner block.
// ----------------------------------------------------------------------------
package kmdg_pkg;

    // Default matrix geometry.
    localparam int NUM_ROWS_DEF = 8;
    localparam int NUM_COLS_DEF = 16;

    // Fixed field widths of the ports.
    localparam int ROW_IDX_W  = 3;
    localparam int ROW_BITS_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ROWS_CFG_W = 4;
    localparam int COUNT_W    = 8;
    localparam int KEYS_W     = 8;
    localparam int POP_W      = 5;

    // Configuration register reset values.
    localparam logic [ROWS_CFG_W-1:0] ROWS_IN_USE_RST     = 4'd8;
    localparam logic [COUNT_W-1:0]    DEBOUNCE_RELOAD_RST = 8'd0;
    localparam logic                  GHOST_CHECK_RST     = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE     = 2'd0,
        CFG_DEBOUNCE_RELOAD = 2'd1,
        CFG_GHOST_CHECK     = 2'd2
    } cfg_index_t;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_STATUS = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic do_update;
        logic do_status;
        logic load_out;
    } cmd_t;

    // Population count of a 16-bit row: four nibble sums, then one add tree.
    function automatic logic [POP_W-1:0] popcount16(input logic [15:0] v);
        logic [2:0] nib [4];
        logic [3:0] half0;
        logic [3:0] half1;
        for (int n = 0; n < 4; n++)
        begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        half0 = 4'(nib[0]) + 4'(nib[1]);
        half1 = 4'(nib[2]) + 4'(nib[3]);
        return POP_W'(half0) + POP_W'(half1);
    endfunction

endpackage

@@ src/kmdg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce and ghost check: controller
// Sequences one row transaction through update, status and output load.
// ----------------------------------------------------------------------------
module kmdg_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output kmdg_pkg::cmd_t cmd
);

    kmdg_pkg::state_t state_reg;
    kmdg_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Next-state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            kmdg_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = kmdg_pkg::ST_UPDATE;
                end
            end
            kmdg_pkg::ST_UPDATE:
            begin
                cmd.do_update = 1'b1;
                state_next    = kmdg_pkg::ST_STATUS;
            end
            kmdg_pkg::ST_STATUS:
            begin
                cmd.do_status = 1'b1;
                state_next    = kmdg_pkg::ST_FINISH;
            end
            kmdg_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = kmdg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmdg_pkg::ST_IDLE;
            end
        endcase
    end

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kmdg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/kmdg_datapath.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce and ghost check: datapath
// Holds the configuration, the two row images, the debounce counter, the
// per-row status registers and the result register.
// ----------------------------------------------------------------------------
module kmdg_datapath
#(
    parameter int NUM_ROWS = kmdg_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLS = kmdg_pkg::NUM_COLS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  kmdg_pkg::cmd_t                     cmd,
    input  logic                               cfg_we,
    input  logic [kmdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmdg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [kmdg_pkg::ROW_IDX_W-1:0]     row_index,
    input  logic [kmdg_pkg::ROW_BITS_W-1:0]    row_bits,
    output logic                               row_changed,
    output logic                               bounce,
    output logic                               scan_done,
    output logic                               stable,
    output logic                               modified,
    output logic                               ghost_present,
    output logic [kmdg_pkg::KEYS_W-1:0]        key_count
);

    localparam int ROW_AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam logic [kmdg_pkg::ROWS_CFG_W-1:0] NROWS_MAX = kmdg_pkg::ROWS_CFG_W'(NUM_ROWS);

    // Configuration registers.
    logic [kmdg_pkg::ROWS_CFG_W-1:0] rows_in_use_reg;
    logic [kmdg_pkg::COUNT_W-1:0]    debounce_reload_reg;
    logic                            ghost_check_reg;

    // Scanner state.
    logic [NUM_COLS-1:0]          bank_a_reg [NUM_ROWS];
    logic [NUM_COLS-1:0]          bank_a_next [NUM_ROWS];
    logic [NUM_COLS-1:0]          bank_b_reg [NUM_ROWS];
    logic [NUM_COLS-1:0]          bank_b_next [NUM_ROWS];
    logic                         bank_sel_reg;
    logic                         bank_sel_next;
    logic [kmdg_pkg::COUNT_W-1:0] count_reg;
    logic [kmdg_pkg::COUNT_W-1:0] count_next;

    // Captured input transaction.
    logic [kmdg_pkg::ROW_IDX_W-1:0] row_idx_reg;
    logic [NUM_COLS-1:0]            row_bits_reg;

    // Per-transaction flags and per-row status.
    logic                      changed_reg;
    logic                      changed_next;
    logic                      bounce_reg;
    logic                      bounce_next;
    logic                      done_reg;
    logic                      done_next;
    logic [kmdg_pkg::POP_W-1:0] pop_reg [NUM_ROWS];
    logic [NUM_ROWS-1:0]       ghost_row_reg;
    logic                      mod_reg;

    // Update-step signals.
    logic [kmdg_pkg::ROWS_CFG_W-1:0] nrows_eff;
    logic [kmdg_pkg::ROWS_CFG_W-1:0] row_wide;
    logic                            in_range;
    logic                            swap;
    logic                            sel_eff;
    logic [ROW_AW-1:0]               row_addr;
    logic [NUM_COLS-1:0]             cur_row;
    logic                            diff;
    logic                            last_row;
    logic [kmdg_pkg::COUNT_W-1:0]    count_after;

    // Status-step signals.
    logic [NUM_COLS-1:0]        cur_img [NUM_ROWS];
    logic [NUM_COLS-1:0]        prev_img [NUM_ROWS];
    logic [kmdg_pkg::POP_W-1:0] pop_next [NUM_ROWS];
    logic [NUM_ROWS-1:0]        ghost_row_next;
    logic                       mod_next;
    logic [kmdg_pkg::KEYS_W-1:0] key_sum;

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg     <= kmdg_pkg::ROWS_IN_USE_RST;
            debounce_reload_reg <= kmdg_pkg::DEBOUNCE_RELOAD_RST;
            ghost_check_reg     <= kmdg_pkg::GHOST_CHECK_RST;
        end
        else if (cfg_we)
        begin
            case (kmdg_pkg::cfg_index_t'(cfg_index))
                kmdg_pkg::CFG_ROWS_IN_USE:
                begin
                    rows_in_use_reg <= cfg_data[kmdg_pkg::ROWS_CFG_W-1:0];
                end
                kmdg_pkg::CFG_DEBOUNCE_RELOAD:
                begin
                    debounce_reload_reg <= cfg_data;
                end
                kmdg_pkg::CFG_GHOST_CHECK:
                begin
                    ghost_check_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Effective row count: zero acts as one, large values clamp to the matrix.
    always_comb
    begin
        if (rows_in_use_reg == '0)
        begin
            nrows_eff = kmdg_pkg::ROWS_CFG_W'(1);
        end
        else if (rows_in_use_reg > NROWS_MAX)
        begin
            nrows_eff = NROWS_MAX;
        end
        else
        begin
            nrows_eff = rows_in_use_reg;
        end
    end

    // Update step: swap banks on row 0 while the counter is zero, store a changed row, run the counter.
    assign row_wide    = kmdg_pkg::ROWS_CFG_W'(row_idx_reg);
    assign in_range    = row_wide < nrows_eff;
    assign swap        = in_range && (row_idx_reg == '0) && (count_reg == '0);
    assign sel_eff     = bank_sel_reg ^ swap;
    assign row_addr    = row_idx_reg[ROW_AW-1:0];
    assign cur_row     = sel_eff ? bank_b_reg[row_addr] : bank_a_reg[row_addr];
    assign diff        = in_range && (cur_row != row_bits_reg);
    assign last_row    = in_range && (row_wide == (nrows_eff - kmdg_pkg::ROWS_CFG_W'(1)));
    assign count_after = diff ? debounce_reload_reg : count_reg;

    always_comb
    begin
        bank_a_next   = bank_a_reg;
        bank_b_next   = bank_b_reg;
        bank_sel_next = bank_sel_reg;
        count_next    = count_reg;
        changed_next  = changed_reg;
        bounce_next   = bounce_reg;
        done_next     = done_reg;
        if (cmd.do_update)
        begin
            bank_sel_next = sel_eff;
            changed_next  = diff;
            bounce_next   = diff && (count_reg != '0);
            done_next     = last_row;
            if (last_row && (count_after != '0))
            begin
                count_next = count_after - kmdg_pkg::COUNT_W'(1);
            end
            else
            begin
                count_next = count_after;
            end
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                if (diff && (row_wide == kmdg_pkg::ROWS_CFG_W'(r)))
                begin
                    if (sel_eff)
                    begin
                        bank_b_next[r] = row_bits_reg;
                    end
                    else
                    begin
                        bank_a_next[r] = row_bits_reg;
                    end
                end
            end
        end
    end

    // Image, bank select and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                bank_a_reg[r] <= '0;
                bank_b_reg[r] <= '0;
            end
            bank_sel_reg <= 1'b0;
            count_reg    <= kmdg_pkg::DEBOUNCE_RELOAD_RST;
            changed_reg  <= 1'b0;
            bounce_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            bank_a_reg   <= bank_a_next;
            bank_b_reg   <= bank_b_next;
            bank_sel_reg <= bank_sel_next;
            count_reg    <= count_next;
            changed_reg  <= changed_next;
            bounce_reg   <= bounce_next;
            done_reg     <= done_next;
        end
    end

    // Input capture; columns beyond the matrix are dropped.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            row_idx_reg  <= row_index;
            row_bits_reg <= row_bits[NUM_COLS-1:0];
        end
    end

    // Status step: per-row key counts, ghost flags and image comparison.
    always_comb
    begin
        mod_next = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            cur_img[r]  = bank_sel_reg ? bank_b_reg[r] : bank_a_reg[r];
            prev_img[r] = bank_sel_reg ? bank_a_reg[r] : bank_b_reg[r];
        end
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            pop_next[r]       = kmdg_pkg::popcount16(kmdg_pkg::ROW_BITS_W'(cur_img[r]));
            ghost_row_next[r] = 1'b0;
            if (cur_img[r] != prev_img[r])
            begin
                mod_next = 1'b1;
            end
            // A row with two or more keys whose keys all show in another row.
            if (ghost_check_reg && ((cur_img[r] & (cur_img[r] - NUM_COLS'(1))) != '0))
            begin
                for (int i = 0; i < NUM_ROWS; i++)
                begin
                    if ((i != r) && ((cur_img[i] & cur_img[r]) == cur_img[r]))
                    begin
                        ghost_row_next[r] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_status)
        begin
            pop_reg       <= pop_next;
            ghost_row_reg <= ghost_row_next;
            mod_reg       <= mod_next;
        end
    end

    // Finish step: total key count over the per-row counts.
    always_comb
    begin
        key_sum = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            key_sum = key_sum + kmdg_pkg::KEYS_W'(pop_reg[r]);
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            row_changed   <= changed_reg;
            bounce        <= bounce_reg;
            scan_done     <= done_reg;
            stable        <= (count_reg == '0);
            modified      <= (count_reg == '0) && mod_reg;
            ghost_present <= |ghost_row_reg;
            key_count     <= key_sum;
        end
    end

endmodule

@@ src/key_matrix_debounce_ghost.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce and ghost check: top level
// Debounced key matrix row scanner with bank swapping and ghost detection.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction carries one scanned row (row_index, row_bits);
//   rows of a pass arrive in order 0 to rows_in_use-1. Every input
//   transaction yields exactly one output transaction with the change and
//   bounce flags of that row and the status of the whole matrix after it.
//   The configuration channel (cfg_valid, cfg_index, cfg_data) is always
//   ready; write it only while no row is in flight.
// Sequence:
//   The row is captured at acceptance; update, status and result load follow
//   in order, each in its own controller state, and the result load waits
//   until the output register is free. One row is processed at a time; a new
//   row is accepted only after the last one is loaded as a result.
// Reset:
//   Both images clear, bank a is current, the debounce counter is zero and
//   the configuration returns to 8 rows, reload 0, ghost check on.
// Stall:
//   A result waits in the output register; the next row is still accepted
//   and finishes into that register once it is taken.
// ----------------------------------------------------------------------------
`include "key_matrix_debounce_ghost_macros.svh"

module key_matrix_debounce_ghost
#(
    parameter int NUM_ROWS = kmdg_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLS = kmdg_pkg::NUM_COLS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [kmdg_pkg::ROW_IDX_W-1:0]     row_index,
    input  logic [kmdg_pkg::ROW_BITS_W-1:0]    row_bits,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               row_changed,
    output logic                               bounce,
    output logic                               scan_done,
    output logic                               stable,
    output logic                               modified,
    output logic                               ghost_present,
    output logic [kmdg_pkg::KEYS_W-1:0]        key_count,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kmdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmdg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    kmdg_pkg::cmd_t cmd;
    logic           in_acc;
    logic           out_free;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    // Handshake terms used by the checks.
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;

    // Sequencing of each row transaction.
    kmdg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Images, counter, status and result registers.
    kmdg_datapath
    #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .row_index     (row_index),
        .row_bits      (row_bits),
        .row_changed   (row_changed),
        .bounce        (bounce),
        .scan_done     (scan_done),
        .stable        (stable),
        .modified      (modified),
        .ghost_present (ghost_present),
        .key_count     (key_count)
    );

    // Design checks.
    `KMDG_ASSERT_NEXT(a_one_row_in_flight, clk, rst_n, in_acc, !in_ready, "row overlap")
    `KMDG_ASSERT_NEXT(a_update_follows_accept, clk, rst_n, in_acc, cmd.do_update, "no update")
    `KMDG_ASSERT_NOW(a_no_result_overwrite, clk, rst_n, cmd.load_out, out_free, "overwrite")
    `KMDG_ASSERT_NOW(a_modified_stable, clk, rst_n, out_valid && modified, stable, "unstable")

endmodule

@@ verif/key_matrix_debounce_ghost_tb.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce and ghost check: testbench
// Sends scanned rows through the valid/ready input channel and checks every
// result against a cycle-free model of the two row images, the bank swap,
// the debounce counter and the ghost check. Random idling on both sides.
// ----------------------------------------------------------------------------

// Status of the matrix reported for one row transaction.
typedef struct packed {
    logic       changed;
    logic       bounce;
    logic       done;
    logic       stable;
    logic       modified;
    logic       ghost;
    logic [7:0] keys;
} scan_status_t;

// Tracks the scanner state and holds the status expected for each row.
class scan_scoreboard;
    logic [3:0]   rows_cfg;
    logic [7:0]   reload_cfg;
    logic         ghost_cfg;
    logic [15:0]  image [2][8];
    logic         bank;
    logic [7:0]   settle_count;
    scan_status_t pending_status [$];
    int           mismatches;
    int           results_seen;

    function new();
        rows_cfg     = kmdg_pkg::ROWS_IN_USE_RST;
        reload_cfg   = kmdg_pkg::DEBOUNCE_RELOAD_RST;
        ghost_cfg    = kmdg_pkg::GHOST_CHECK_RST;
        bank         = 1'b0;
        settle_count = 8'd0;
        mismatches   = 0;
        results_seen = 0;
        for (int b = 0; b < 2; b++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                image[b][r] = 16'h0000;
            end
        end
    endfunction

    function int pending();
        return pending_status.size();
    endfunction

    // Apply a register write; only the register's own bits are kept.
    function void write_reg(kmdg_pkg::cfg_index_t idx, logic [7:0] data);
        case (idx)
            kmdg_pkg::CFG_ROWS_IN_USE:     rows_cfg   = data[3:0];
            kmdg_pkg::CFG_DEBOUNCE_RELOAD: reload_cfg = data;
            kmdg_pkg::CFG_GHOST_CHECK:     ghost_cfg  = data[0];
            default: ;
        endcase
    endfunction

    // Advance the model by one accepted row and queue the status it yields.
    function void accept_row(logic [2:0] row, logic [15:0] bits);
        int           nrows;
        int           keys;
        logic [15:0]  x;
        scan_status_t st;
        nrows = (rows_cfg == 4'd0) ? 1 : (rows_cfg > 4'd8) ? 8 : int'(rows_cfg);
        st = '0;
        // A row beyond the pass length leaves the state alone.
        if (int'(row) < nrows)
        begin
            if (row == 3'd0 && settle_count == 8'd0)
            begin
                bank = ~bank;
            end
            if (image[bank][row] != bits)
            begin
                image[bank][row] = bits;
                st.changed       = 1'b1;
                st.bounce        = (settle_count != 8'd0);
                settle_count     = reload_cfg;
            end
            if (int'(row) == nrows - 1)
            begin
                st.done = 1'b1;
                if (settle_count != 8'd0)
                begin
                    settle_count--;
                end
            end
        end
        // Status of the whole matrix after this row.
        st.stable = (settle_count == 8'd0);
        keys = 0;
        for (int r = 0; r < 8; r++)
        begin
            x = image[bank][r];
            if (x != image[~bank][r])
            begin
                st.modified = 1'b1;
            end
            keys += $countones(x);
            if (ghost_cfg && $countones(x) >= 2)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (i != r && (image[bank][i] & x) == x)
                    begin
                        st.ghost = 1'b1;
                    end
                end
            end
        end
        if (!st.stable)
        begin
            st.modified = 1'b0;
        end
        st.keys = 8'(keys);
        pending_status.push_back(st);
    endfunction

    task report(string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task compare_field(string name, int got, int want);
        if (got != want)
        begin
            report($sformatf("result %0d field %s is %0d, expected %0d",
                             results_seen, name, got, want));
        end
    endtask

    // Compare one accepted result with the oldest expected status.
    task check_status(scan_status_t got);
        scan_status_t want;
        if (pending_status.size() == 0)
        begin
            report("result arrived with no row outstanding");
        end
        else
        begin
            want = pending_status.pop_front();
            compare_field("row_changed", got.changed, want.changed);
            compare_field("bounce", got.bounce, want.bounce);
            compare_field("scan_done", got.done, want.done);
            compare_field("stable", got.stable, want.stable);
            compare_field("modified", got.modified, want.modified);
            compare_field("ghost_present", got.ghost, want.ghost);
            compare_field("key_count", got.keys, want.keys);
        end
        results_seen++;
    endtask
endclass

module key_matrix_debounce_ghost_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kmdg_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  out_valid;
    logic                  out_ready;
    logic                  row_changed;
    logic                  bounce;
    logic                  scan_done;
    logic                  stable;
    logic                  modified;
    logic                  ghost_present;
    logic [KEYS_W-1:0]     key_count;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    scan_scoreboard sb = new();
    bit             calm = 1'b0;
    int             random_rows = 0;
    logic [15:0]    sent_rows [8];

    key_matrix_debounce_ghost DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .row_index     (row_index),
        .row_bits      (row_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row_changed   (row_changed),
        .bounce        (bounce),
        .scan_done     (scan_done),
        .stable        (stable),
        .modified      (modified),
        .ghost_present (ghost_present),
        .key_count     (key_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Run limit well above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result monitor: every accepted output transaction is checked.
    always @(posedge clk)
    begin : result_monitor
        scan_status_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {row_changed, bounce, scan_done, stable, modified,
                    ghost_present, key_count};
            sb.check_status(seen);
        end
    end

    // Output stalls in random bursts, none in the calm part of the run.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (calm || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // One row transaction; valid stays high afterwards until lowered.
    task automatic send_row(input logic [2:0] row, input logic [15:0] bits);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_index <= row;
        row_bits  <= bits;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.accept_row(row, bits);
    endtask

    // One register write transaction; the caller lowers cfg_valid.
    task automatic put_reg(input cfg_index_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Write all three registers; unused data bits carry random values.
    task automatic write_config(input logic [3:0] rows, input logic [7:0] reload,
                                input logic ghost);
        put_reg(CFG_ROWS_IN_USE, {4'($urandom), rows});
        put_reg(CFG_DEBOUNCE_RELOAD, reload);
        put_reg(CFG_GHOST_CHECK, {7'($urandom), ghost});
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every outstanding row has its result.
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.pending() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    // Mostly repeat the last value of a row so that passes settle.
    function automatic logic [15:0] next_bits(input int row);
        logic [15:0] v;
        case ($urandom_range(0, 9))
            5:       v = sent_rows[row] ^ (16'h0001 << $urandom_range(0, 15));
            6:       v = 16'($urandom);
            7:       v = 16'h0000;
            8:       v = 16'hFFFF;
            9:       v = 16'($urandom) & 16'($urandom) & 16'($urandom);
            default: v = sent_rows[row];
        endcase
        sent_rows[row] = v;
        return v;
    endfunction

    // One scan pass with occasional stray rows and early ends.
    task automatic run_pass(input logic [3:0] rows);
        int nrows;
        nrows = (rows == 4'd0) ? 1 : (rows > 4'd8) ? 8 : int'(rows);
        for (int r = 0; r < nrows; r++)
        begin
            if (!calm && $urandom_range(0, 19) == 0)
            begin
                send_row(3'($urandom), 16'($urandom));
                random_rows++;
            end
            if (!calm && $urandom_range(0, 29) == 0)
            begin
                break;
            end
            send_row(3'(r), next_bits(r));
            random_rows++;
        end
    endtask

    initial
    begin
        logic [3:0] rows;
        logic [7:0] reload;
        logic       ghost;
        int         phase;
        int         phase_end;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        row_index = '0;
        row_bits  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int r = 0; r < 8; r++)
        begin
            sent_rows[r] = 16'h0000;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full pass at reset settings: empty and full rows, single keys,
        // a two-key row covered by another row, alternating columns.
        send_row(3'd0, 16'h0000);
        send_row(3'd1, 16'hFFFF);
        send_row(3'd2, 16'h0001);
        send_row(3'd3, 16'h8000);
        send_row(3'd4, 16'h0003);
        send_row(3'd5, 16'h0007);
        send_row(3'd6, 16'hAAAA);
        send_row(3'd7, 16'h5555);
        drain_results();

        // Four-row pass with a reload: changes while counting are bounces,
        // and a row past the pass length is ignored.
        write_config(4'd4, 8'd2, 1'b0);
        send_row(3'd0, 16'h1234);
        send_row(3'd1, 16'h0000);
        send_row(3'd5, 16'hFFFF);
        send_row(3'd2, 16'hFFFF);
        send_row(3'd3, 16'h00F0);
        drain_results();

        // Reload rewritten while the counter still runs: the count goes on.
        write_config(4'd4, 8'd0, 1'b1);
        send_row(3'd0, 16'h1234);
        send_row(3'd1, 16'h0000);
        send_row(3'd2, 16'hFFFF);
        send_row(3'd3, 16'h00F0);
        drain_results();

        // Zero rows acts as a single-row pass: swap, store, then decrement.
        write_config(4'd0, 8'd1, 1'b1);
        send_row(3'd0, 16'h0F0F);
        send_row(3'd0, 16'h0F0F);
        send_row(3'd3, 16'h0001);
        drain_results();

        // Random phases, each under its own register settings.
        phase = 0;
        while (random_rows < 440)
        begin
            if (phase == 0)
            begin
                rows   = 4'd15;
                reload = 8'd255;
                ghost  = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       rows = 4'd8;
                    1:       rows = 4'd1;
                    2:       rows = 4'd0;
                    3:       rows = 4'($urandom_range(9, 15));
                    default: rows = 4'($urandom_range(2, 7));
                endcase
                case ($urandom_range(0, 7))
                    0:       reload = 8'd0;
                    1:       reload = 8'd255;
                    2:       reload = 8'd1;
                    default: reload = 8'($urandom_range(0, 3));
                endcase
                ghost = 1'($urandom);
            end
            write_config(rows, reload, ghost);
            phase_end = random_rows + 40;
            while (random_rows < phase_end)
            begin
                run_pass(rows);
            end
            drain_results();
            phase++;
        end

        // Final stretch with no idling on either side.
        calm = 1'b1;
        write_config(4'd8, 8'd1, 1'b1);
        phase_end = random_rows + 60;
        while (random_rows < phase_end)
        begin
            run_pass(4'd8);
        end
        drain_results();

        if (sb.pending() != 0)
        begin
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        end
        if (sb.mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
